### sv/rpmpi_pkg.sv
// ----------------------------------------------------------------------------
// rpmpi_pkg
// Shared types and constants of the RPM PI speed loop.
// ----------------------------------------------------------------------------
package rpmpi_pkg;

	// Magnitude width of the serial datapath and multiplier digit count.
	localparam int MW = 50;
	localparam int BW = 17;
	localparam int DW = 32;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_ENTER = 2'd1,
		CMD_EXIT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INT_GAIN   = 3'd1;
	localparam logic [2:0] REG_TGT_MAX    = 3'd2;
	localparam logic [2:0] REG_BASE_LOW   = 3'd3;
	localparam logic [2:0] REG_BASE_HIGH  = 3'd4;
	localparam logic [2:0] REG_OUT_LOW    = 3'd5;
	localparam logic [2:0] REG_OUT_HIGH   = 3'd6;
	localparam logic [2:0] REG_CORR_LIMIT = 3'd7;

	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] pulse_in;
		logic [15:0] rpm_measured;
		logic        rpm_ok;
		logic [39:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic [10:0] pwm_out;
		logic        sat_high;
		logic        sat_low;
		logic        integrator_held;
	} out_item_t;

endpackage

### sv/rpmpi_smul.sv
// ----------------------------------------------------------------------------
// rpmpi_smul
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module rpmpi_smul import rpmpi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [MW-1:0] p
);
	logic [MW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [MW-1:0] acc_q;
	logic [4:0]    cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[MW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign p = acc_q;
endmodule

### sv/rpmpi_sdiv.sv
// ----------------------------------------------------------------------------
// rpmpi_sdiv
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rpmpi_sdiv import rpmpi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] n,
	input  logic [DW-1:0] d,
	output logic          done,
	output logic [MW-1:0] q,
	output logic          rem_nz
);
	logic [MW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] rem_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, n_q[MW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
			n_q   <= {n_q[MW-2:0], fits};
		end
	end

	assign q      = n_q;
	assign rem_nz = rem_q != '0;
endmodule

### sv/rpm_pi_loop_antiwindup.sv
// ----------------------------------------------------------------------------
// rpm_pi_loop_antiwindup
// PI rotor speed loop with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// A control tick gives one result beat after it is accepted. Each of the five
// steps runs launch, a 17-bit serial multiply, and post; three of them add a
// serial divide before post. An output state follows, which waits while the
// output is stalled. Enter and exit commands give no beat.
// One tick is in flight at a time; the next is taken in the cycle after the
// result is loaded into the output register.
// Reset clears the integrator, the last timestamp and the handshake state and
// loads the default gains and limits.
module rpm_pi_loop_antiwindup import rpmpi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LAUNCH = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_POST   = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	localparam logic [2:0] STEP_BASE = 3'd0;
	localparam logic [2:0] STEP_TGT  = 3'd1;
	localparam logic [2:0] STEP_INT  = 3'd2;
	localparam logic [2:0] STEP_PROP = 3'd3;
	localparam logic [2:0] STEP_ICOR = 3'd4;

	localparam logic signed [MW:0] I_LIM = (MW+1)'(64'sd5000000000);

	state_t state_q;
	logic [2:0] step_q;

	logic [15:0] prop_q, ig_q, tmax_q;
	logic [10:0] bl_q, bh_q, ol_q, oh_q;
	logic [6:0]  cl_q;

	logic signed [33:0] integ_q, next_q;
	logic [39:0] last_q;

	logic [9:0]  x_q;
	logic signed [11:0] dlt_q;
	logic [24:0] meas_q;
	logic [16:0] dt_q;
	logic signed [16:0] base_q;
	logic signed [25:0] err_q;
	logic signed [26:0] pcorr_q;
	logic signed [18:0] icorr_q;
	logic neg_q;

	logic out_valid_q;
	out_item_t out_q;

	logic accept;
	logic mul_start, mul_done, div_start, div_done, rem_nz;
	logic [MW-1:0] mul_a, mul_p, div_q;
	logic [BW-1:0] mul_b;
	logic [DW-1:0] div_d;
	logic needs_div;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign needs_div = step_q == STEP_BASE || step_q == STEP_TGT || step_q == STEP_ICOR;

	// Tick preparation.
	logic [11:0] pc;
	logic [39:0] dt0;
	logic [16:0] dt_new;
	always_comb begin
		pc = in_data.pulse_in;
		if (pc < 12'd1000) begin
			pc = 12'd1000;
		end else if (pc > 12'd2000) begin
			pc = 12'd2000;
		end
		dt0 = in_data.time_us - last_q;
		if (last_q != '0 && in_data.time_us > last_q && dt0 <= 40'd100000) begin
			dt_new = dt0[16:0];
		end else begin
			dt_new = 17'd10000;
		end
	end

	// Operand selection for the shared multiplier, and divisor selection.
	logic [25:0] err_abs;
	logic [33:0] next_abs;
	logic [11:0] dlt_abs;
	logic        op_neg;
	always_comb begin
		err_abs  = err_q[25] ? 26'(-err_q) : 26'(err_q);
		next_abs = next_q[33] ? 34'(-next_q) : 34'(next_q);
		dlt_abs  = dlt_q[11] ? 12'(-dlt_q) : 12'(dlt_q);
		mul_a  = '0;
		mul_b  = '0;
		op_neg = 1'b0;
		div_d  = 32'd1000;
		unique case (step_q)
			STEP_BASE: begin
				mul_a  = MW'({x_q, 4'b0});
				mul_b  = BW'(dlt_abs);
				op_neg = dlt_q[11];
			end
			STEP_TGT: begin
				mul_a = MW'({x_q, 4'b0});
				mul_b = BW'(tmax_q);
			end
			STEP_INT: begin
				mul_a  = MW'(err_abs);
				mul_b  = dt_q;
				op_neg = err_q[25];
			end
			STEP_PROP: begin
				mul_a  = MW'(err_abs);
				mul_b  = BW'(prop_q);
				op_neg = err_q[25];
			end
			STEP_ICOR: begin
				mul_a  = MW'(next_abs);
				mul_b  = BW'(ig_q);
				op_neg = next_q[33];
				div_d  = 32'd4096000000;
			end
			default: begin
			end
		endcase
	end

	assign mul_start = state_q == ST_LAUNCH;
	assign div_start = state_q == ST_MUL && mul_done && needs_div;

	rpmpi_smul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	rpmpi_sdiv u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(mul_p), .d(div_d), .done(div_done), .q(div_q), .rem_nz(rem_nz)
	);

	// Signed, floored result of the current step and the clamped integrator sum.
	logic signed [MW:0] mag, sval, psig, isum, nsat;
	always_comb begin
		psig = neg_q ? -(MW+1)'(signed'({1'b0, mul_p})) : (MW+1)'(signed'({1'b0, mul_p}));
		if (needs_div) begin
			mag  = (MW+1)'(signed'({1'b0, div_q})) + (MW+1)'(neg_q && rem_nz);
			sval = neg_q ? -mag : mag;
		end else begin
			mag  = psig;
			sval = (step_q == STEP_INT) ? (psig >>> 4) : (psig >>> 16);
		end
		isum = (MW+1)'(integ_q) + sval;
		if (isum < -I_LIM) begin
			nsat = -I_LIM;
		end else if (isum > I_LIM) begin
			nsat = I_LIM;
		end else begin
			nsat = isum;
		end
	end

	// Final combine, clamps and anti-windup decision.
	logic signed [27:0] corr, climit, sum, lo16, hi16, out16;
	logic sh, sl, take;
	always_comb begin
		corr   = 28'(pcorr_q) + 28'(icorr_q);
		climit = 28'(signed'({1'b0, cl_q, 4'b0}));
		if (corr < -climit) begin
			corr = -climit;
		end else if (corr > climit) begin
			corr = climit;
		end
		sum  = 28'(base_q) + corr;
		lo16 = 28'(signed'({1'b0, ol_q, 4'b0}));
		hi16 = 28'(signed'({1'b0, oh_q, 4'b0}));
		if (sum < lo16) begin
			out16 = lo16;
		end else if (sum > hi16) begin
			out16 = hi16;
		end else begin
			out16 = sum;
		end
		sh   = out16 >= hi16 - 28'sd8;
		sl   = out16 <= lo16 + 28'sd8;
		take = (!sh && !sl) || (sh && err_q < 0) || (sl && err_q > 0);
	end

	logic out_load;
	assign out_load = state_q == ST_OUT && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_BASE;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
			last_q      <= '0;
			prop_q      <= 16'd1311;
			ig_q        <= 16'd328;
			tmax_q      <= 16'd11700;
			bl_q        <= 11'd1500;
			bh_q        <= 11'd1850;
			ol_q        <= 11'd1500;
			oh_q        <= 11'd1875;
			cl_q        <= 7'd10;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PROP_GAIN:  prop_q <= cfg_data;
					REG_INT_GAIN:   ig_q   <= cfg_data;
					REG_TGT_MAX:    tmax_q <= cfg_data;
					REG_BASE_LOW:   bl_q   <= cfg_data[10:0];
					REG_BASE_HIGH:  bh_q   <= cfg_data[10:0];
					REG_OUT_LOW:    ol_q   <= cfg_data[10:0];
					REG_OUT_HIGH:   oh_q   <= cfg_data[10:0];
					REG_CORR_LIMIT: cl_q   <= cfg_data[6:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd_t'(in_data.command))
							CMD_TICK: begin
								last_q  <= in_data.time_us;
								step_q  <= STEP_BASE;
								state_q <= ST_LAUNCH;
							end
							CMD_ENTER: begin
								integ_q <= '0;
								last_q  <= in_data.time_us;
							end
							CMD_EXIT: begin
								integ_q <= '0;
								last_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LAUNCH: state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_done) begin
						state_q <= needs_div ? ST_DIV : ST_POST;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (step_q == STEP_ICOR) begin
						state_q <= ST_OUT;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= ST_LAUNCH;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						if (take) begin
							integ_q <= next_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= 10'(pc - 12'd1000);
			dlt_q  <= 12'(signed'({1'b0, bh_q})) - 12'(signed'({1'b0, bl_q}));
			meas_q <= in_data.rpm_ok ? {in_data.rpm_measured, 4'b0} : '0;
			dt_q   <= dt_new;
		end
		if (state_q == ST_LAUNCH) begin
			neg_q <= op_neg;
		end
		if (state_q == ST_POST) begin
			unique case (step_q)
				STEP_BASE: base_q  <= 17'(signed'({1'b0, bl_q, 4'b0})) + 17'(sval);
				STEP_TGT:  err_q   <= 26'(sval) - 26'(signed'({1'b0, meas_q}));
				STEP_INT:  next_q  <= 34'(nsat);
				STEP_PROP: pcorr_q <= 27'(sval);
				STEP_ICOR: icorr_q <= 19'(sval);
				default: begin
				end
			endcase
		end
		if (out_load) begin
			out_q.pwm_out         <= out16[14:4];
			out_q.sat_high        <= sh;
			out_q.sat_low         <= sl;
			out_q.integrator_held <= !take;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

### sv/rpmpi_checker.sv
// ----------------------------------------------------------------------------
// rpmpi_checker
// Port-level checks of the RPM PI speed loop, bound to the top level.
// ----------------------------------------------------------------------------
module rpmpi_checker import rpmpi_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	// A stalled result beat must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Anti-windup only holds the integrator at a saturated output.
	a_held_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_data.integrator_held || out_data.sat_high || out_data.sat_low)
		else $error("integrator held without saturation");

	// An accepted control tick makes the loop stall its input.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.command == CMD_TICK |=> in_stall)
		else $error("input taken during a tick");

	// No result comes out of reset.
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");
endmodule

bind rpm_pi_loop_antiwindup rpmpi_checker u_rpmpi_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
